/* rtl/fifo_queue_with_search_top_macros.svh */
// Assertion macros for the searchable FIFO queue.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef FIFO_QUEUE_WITH_SEARCH_TOP_MACROS_SVH
`define FIFO_QUEUE_WITH_SEARCH_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// Checked property, disabled while reset is active
`define SQS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked property, also evaluated during reset
`define SQS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SQS_ASSERT(lbl, clk, rstn, prop, msg)
`define SQS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/sqs_pkg.sv */
// Shared types and constants for the searchable FIFO queue.
// No dependencies; imported by every module of the block.
package sqs_pkg;

    // Fixed field widths of the stream payloads
    localparam int CMD_W    = 2;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 5;
    localparam int OCC_W    = 5;
    localparam int M_TDATA_W = 48;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ    = 2'd0,
        CMD_DEQ    = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // Controls broadcast to every cell
    typedef struct packed {
        logic shift;   // move every word one cell toward the head
        logic cmp;     // register the compare against the search word
    } cell_ctrl_t;

endpackage

/* rtl/sqs_cell.sv */
// One storage cell of the queue chain: a word, its load/shift path and a comparator.
// Depends on sqs_pkg.
module sqs_cell
    import sqs_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int CNT_W      = 5,
    parameter int IDX        = 0
)
(
    input  logic                  clk,
    input  cell_ctrl_t            ctrl,
    input  logic                  load_en,
    input  logic [DATA_WIDTH-1:0] load_data,
    input  logic [DATA_WIDTH-1:0] neighbor_data,
    input  logic [CNT_W-1:0]      count,
    output logic [DATA_WIDTH-1:0] data,
    output logic                  match
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic                  match_reg;
    logic                  in_range;

    // cell holds a live word when its slot lies below the fill count
    assign in_range = (count > CNT_W'(IDX));

    // word storage: shift toward head on dequeue, load on enqueue
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            data_reg <= neighbor_data;
        end
        else if (load_en)
        begin
            data_reg <= load_data;
        end
    end

    // registered compare, search word is the same as load_data
    always_ff @(posedge clk)
    begin
        match_reg <= ctrl.cmp && in_range && (data_reg == load_data);
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

/* rtl/sqs_find_first.sv */
// Find-first over the cell match flags; returns the 1-based cell position.
// Depends on sqs_pkg for nothing but house consistency of widths via parameters.
module sqs_find_first
    import sqs_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int CNT_W = 5
)
(
    input  logic [DEPTH-1:0] match,
    output logic             found,
    output logic [CNT_W-1:0] position
);

    logic [DEPTH-1:0] first;

    // a cell is first when it matches and no cell nearer the head does
    always_comb
    begin
        logic [DEPTH-1:0] lower_mask;
        for (int i = 0; i < DEPTH; i++)
        begin
            lower_mask = (DEPTH'(1) << i) - DEPTH'(1);
            first[i]   = match[i] && ((match & lower_mask) == '0);
        end
    end

    // encode the one-hot first flag
    always_comb
    begin
        position = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            position = position | (first[i] ? CNT_W'(i + 1) : CNT_W'(0));
        end
    end

    assign found = |match;

endmodule

/* rtl/fifo_queue_with_search_top.sv */
// Searchable FIFO queue: a chain of DEPTH cells, head word always in cell 0.
// An accepted item passes the execute state, then the done state (encode), then the output register.
// No new item is accepted until the result of the last one is loaded into the output register.
// Search compares every cell in parallel into registered match flags, then a find-first picks the position.
// Reset (rst_n low, asynchronous) empties the queue; stored words need no clearing.
`include "fifo_queue_with_search_top_macros.svh"
module fifo_queue_with_search_top
    import sqs_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [WORD_W-1:0]    s_axis_tdata,   // [31:0] data_word
    input  logic [CMD_W-1:0]     s_axis_tuser,   // [1:0] cmd
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // [31:0] head_word, [32] found,
                                                 // [37:33] position, [42:38] occupancy
    output logic [STATUS_W-1:0]  m_axis_tuser    // [1:0] status
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  out_valid_reg, out_valid_next;

    logic [CMD_W-1:0]      cmd_reg;
    logic [DATA_WIDTH-1:0] word_reg;
    status_t               status_reg, status_next;
    logic [DATA_WIDTH-1:0] head_reg, head_next;

    status_t               out_status_reg;
    logic [WORD_W-1:0]     out_head_reg;
    logic                  out_found_reg;
    logic [POS_W-1:0]      out_pos_reg;
    logic [OCC_W-1:0]      out_occ_reg;

    logic                  in_xfer;
    logic                  out_load;
    logic                  is_exec;
    logic                  full;
    logic                  empty;
    logic                  enq_ok;
    logic                  deq_ok;
    cell_ctrl_t            cell_ctrl;

    logic [DATA_WIDTH-1:0]        cell_data [DEPTH];
    logic [DEPTH-1:0]             cell_match;
    logic [DEPTH-1:0]             cell_load;
    logic                         hit;
    logic [CNT_W-1:0]             hit_pos;

    logic [DATA_WIDTH+WORD_W-1:0] in_word_wide;
    logic [DATA_WIDTH+WORD_W-1:0] head_wide;
    logic [CNT_W+POS_W-1:0]       pos_wide;
    logic [CNT_W+OCC_W-1:0]       occ_wide;

    // handshakes
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);

    // width adaptation between stream fields and internal words
    assign in_word_wide = {{DATA_WIDTH{1'b0}}, s_axis_tdata};
    assign head_wide    = {{WORD_W{1'b0}}, head_reg};
    assign pos_wide     = {{POS_W{1'b0}}, hit_pos};
    assign occ_wide     = {{OCC_W{1'b0}}, count_reg};

    // command decode in the execute cycle
    assign is_exec = (state_reg == ST_EXEC);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign enq_ok  = is_exec && (cmd_reg == CMD_ENQ) && !full;
    assign deq_ok  = is_exec && (cmd_reg == CMD_DEQ) && !empty;
    assign cell_ctrl.shift = deq_ok;
    // compare kept running through DONE so a stalled result keeps its match flags
    assign cell_ctrl.cmp   = (is_exec || (state_reg == ST_DONE)) && (cmd_reg == CMD_SEARCH);

    // status, dequeued word and fill count for this item
    always_comb
    begin
        count_next = count_reg;
        if (enq_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (deq_ok)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        head_next = deq_ok ? cell_data[0] : '0;
        unique case (cmd_reg) inside
            CMD_ENQ:             status_next = full ? STAT_FULL : STAT_OK;
            CMD_DEQ, CMD_SEARCH: status_next = empty ? STAT_EMPTY : STAT_OK;
            default:             status_next = STAT_OK;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_xfer) state_next = ST_EXEC;
            ST_EXEC: state_next = ST_DONE;
            ST_DONE: if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // output register valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // item capture and execute results
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg  <= s_axis_tuser;
            word_reg <= in_word_wide[DATA_WIDTH-1:0];
        end
        if (is_exec)
        begin
            status_reg <= status_next;
            head_reg   <= head_next;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_head_reg   <= head_wide[WORD_W-1:0];
            out_found_reg  <= hit;
            out_pos_reg    <= pos_wide[POS_W-1:0];
            out_occ_reg    <= occ_wide[OCC_W-1:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {{(M_TDATA_W - WORD_W - 1 - POS_W - OCC_W){1'b0}},
                            out_occ_reg, out_pos_reg, out_found_reg, out_head_reg};

    // chain of cells, cell 0 holds the head word
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] neighbor;

        if (i == DEPTH - 1)
        begin : g_last
            assign neighbor = cell_data[i];
        end
        else
        begin : g_mid
            assign neighbor = cell_data[i+1];
        end

        assign cell_load[i] = enq_ok && (count_reg == CNT_W'(i));

        sqs_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .IDX        (i)
        ) u_cell (
            .clk           (clk),
            .ctrl          (cell_ctrl),
            .load_en       (cell_load[i]),
            .load_data     (word_reg),
            .neighbor_data (neighbor),
            .count         (count_reg),
            .data          (cell_data[i]),
            .match         (cell_match[i])
        );
    end

    // first match nearest the head
    sqs_find_first #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_find_first (
        .match    (cell_match),
        .found    (hit),
        .position (hit_pos)
    );

    // checks
    `SQS_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH), "fill count above depth")
    `SQS_ASSERT(a_accept_exec, clk, rst_n, in_xfer |=> (state_reg == ST_EXEC), "accept without execute")
    `SQS_ASSERT(a_count_only_exec, clk, rst_n, (state_reg != ST_EXEC) |=> $stable(count_reg), "count moved outside execute")
    `SQS_ASSERT(a_found_pos, clk, rst_n, (out_valid_reg && out_found_reg) |-> (hit_pos != '0 || out_pos_reg != '0 || CNT_W > POS_W), "found with no position")
    `SQS_ASSERT(a_one_cell_load, clk, rst_n, $onehot0(cell_load), "more than one cell loaded")

endmodule

/* tb/tb.sv */
// Testbench for the searchable FIFO queue: directed edge cases, then random
// enqueue/dequeue/search traffic checked against an in-bench queue model.
// Depends on sqs_pkg and fifo_queue_with_search_top.
module tb;
    import sqs_pkg::*;

    localparam int QDEPTH       = 16;
    localparam int DRAIN_CYCLES = 12;
    localparam int GAP_PCT      = 22;

    // Result tdata layout, lowest field last
    typedef struct packed {
        logic [4:0]        pad;
        logic [OCC_W-1:0]  occupancy;
        logic [POS_W-1:0]  position;
        logic              found;
        logic [WORD_W-1:0] head_word;
    } result_data_t;

    typedef struct {
        status_t           status;
        logic [WORD_W-1:0] head_word;
        logic              found;
        logic [POS_W-1:0]  position;
        logic [OCC_W-1:0]  occupancy;
    } queue_response_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [WORD_W-1:0]    s_axis_tdata;
    logic [CMD_W-1:0]     s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]  m_axis_tuser;

    // Shadow copy of the queue
    logic [WORD_W-1:0] ring_words [QDEPTH];
    logic [3:0]        ring_head  = '0;
    logic [3:0]        ring_tail  = '0;
    logic [OCC_W-1:0]  ring_count = '0;

    queue_response_t pending_responses [$];
    int              mismatch_count = 0;
    bit              gaps_on   = 1'b1;
    bit              stalls_on = 1'b1;

    fifo_queue_with_search_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Apply one command to the shadow queue and return the response it should give
    function automatic queue_response_t predict_queue_response(cmd_t c, logic [WORD_W-1:0] w);
        queue_response_t r;
        logic [3:0]      slot;
        int              i;
        r.status    = STAT_OK;
        r.head_word = '0;
        r.found     = 1'b0;
        r.position  = '0;
        case (c)
            CMD_ENQ:
            begin
                if (ring_count == QDEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    ring_words[ring_tail] = w;
                    ring_tail  = ring_tail + 4'd1;
                    ring_count = ring_count + 5'd1;
                end
            end
            CMD_DEQ:
            begin
                if (ring_count == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    r.head_word = ring_words[ring_head];
                    ring_head  = ring_head + 4'd1;
                    ring_count = ring_count - 5'd1;
                end
            end
            CMD_SEARCH:
            begin
                if (ring_count == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    // first match from the head wins
                    i = 0;
                    while (i < ring_count && !r.found)
                    begin
                        slot = ring_head + 4'(i);
                        if (ring_words[slot] == w)
                        begin
                            r.found    = 1'b1;
                            r.position = 5'(i + 1);
                        end
                        i++;
                    end
                end
            end
            default: ;
        endcase
        r.occupancy = ring_count;
        return r;
    endfunction

    // One input transfer; valid stays high afterwards so back-to-back items need no gap
    task automatic send_item(cmd_t c, logic [WORD_W-1:0] w);
        while (gaps_on && $urandom_range(99) < GAP_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c;
        s_axis_tdata  <= w;
        do @(posedge clk); while (!s_axis_tready);
        pending_responses.push_back(predict_queue_response(c, w));
    endtask

    // Stop sending until every outstanding response is back
    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
    endtask

    // Receiver backpressure
    always @(posedge clk)
    begin
        if (stalls_on)
            m_axis_tready <= ($urandom_range(99) >= GAP_PCT);
        else
            m_axis_tready <= 1'b1;
    end

    // Response checker
    always @(posedge clk)
    begin
        queue_response_t want;
        result_data_t    got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (pending_responses.size() == 0)
            begin
                $error("response transfer with no item outstanding");
                mismatch_count++;
            end
            else
            begin
                want = pending_responses.pop_front();
                if (m_axis_tuser !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
                    mismatch_count++;
                end
                if (got.head_word !== want.head_word)
                begin
                    $error("head_word: expected %h, actual %h", want.head_word, got.head_word);
                    mismatch_count++;
                end
                if (got.found !== want.found)
                begin
                    $error("found: expected %0d, actual %0d", want.found, got.found);
                    mismatch_count++;
                end
                if (got.position !== want.position)
                begin
                    $error("position: expected %0d, actual %0d", want.position, got.position);
                    mismatch_count++;
                end
                if (got.occupancy !== want.occupancy)
                begin
                    $error("occupancy: expected %0d, actual %0d", want.occupancy,
                           got.occupancy);
                    mismatch_count++;
                end
            end
        end
    end

    // Dequeue, search and no-op against an empty queue
    task automatic test_empty_queue();
        send_item(CMD_DEQ, 32'h0000_0000);
        send_item(CMD_SEARCH, 32'h0000_0000);
        send_item(CMD_NOP, 32'hFFFF_FFFF);
    endtask

    // Fill to the brim, overflow, search hits near the head and at the tail, duplicate and miss
    task automatic test_fill_and_overflow();
        int k;
        send_item(CMD_ENQ, 32'h0000_0000);
        send_item(CMD_ENQ, 32'hFFFF_FFFF);
        for (k = 2; k < QDEPTH - 2; k++)
            send_item(CMD_ENQ, 32'h1000_0000 + k);
        send_item(CMD_ENQ, 32'hFFFF_FFFF);      // duplicate, farther from the head
        send_item(CMD_ENQ, 32'h8000_0001);
        send_item(CMD_ENQ, 32'hDEAD_BEEF);      // full, dropped
        send_item(CMD_SEARCH, 32'hFFFF_FFFF);
        send_item(CMD_SEARCH, 32'h8000_0001);
        send_item(CMD_SEARCH, 32'hDEAD_BEEF);
        send_item(CMD_NOP, 32'h5555_5555);
        send_item(CMD_DEQ, 32'hAAAA_AAAA);
    endtask

    // Word for a random item: small pool for duplicates, stored words for search hits
    function automatic logic [WORD_W-1:0] pick_word(cmd_t c);
        logic [3:0] slot;
        if (c == CMD_SEARCH && ring_count != 0 && $urandom_range(99) < 60)
        begin
            slot = ring_head + 4'($urandom_range(ring_count - 1));
            return ring_words[slot];
        end
        if ($urandom_range(99) < 30)
            return WORD_W'($urandom_range(7));
        return $urandom;
    endfunction

    // Random traffic with a given command mix; what is left over goes to the unused code
    task automatic run_mix(int n, int enq_pct, int deq_pct, int search_pct);
        int   k;
        int   r;
        cmd_t c;
        for (k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            if (r < enq_pct)
                c = CMD_ENQ;
            else if (r < enq_pct + deq_pct)
                c = CMD_DEQ;
            else if (r < enq_pct + deq_pct + search_pct)
                c = CMD_SEARCH;
            else
                c = CMD_NOP;
            send_item(c, pick_word(c));
        end
    endtask

    // Fill-heavy, drain-heavy, search-heavy with no idling, then balanced
    task automatic test_random_traffic();
        run_mix(100, 60, 20, 16);
        wait_until_drained();
        run_mix(100, 25, 55, 16);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        run_mix(100, 35, 30, 32);
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        run_mix(100, 42, 36, 18);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_NOP;
        m_axis_tready <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_fill_and_overflow();
        test_random_traffic();

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #400000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/sqs_pkg.sv
rtl/sqs_cell.sv
rtl/sqs_find_first.sv
rtl/fifo_queue_with_search_top.sv
tb/tb.sv
